// File: sv/bch_255_71_systematic_encoder_core_assert.svh
// Assertion helpers for the BCH(255,71) encoder core.
// Both expect clk and rst_n in scope.
`ifndef BCH_255_71_SYSTEMATIC_ENCODER_CORE_ASSERT_SVH
`define BCH_255_71_SYSTEMATIC_ENCODER_CORE_ASSERT_SVH

// same-cycle implication
`define BCH255_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCH255_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bch255_pkg.sv
package bch255_pkg;

  localparam int unsigned PAR_BYTES  = 23;
  localparam int unsigned PAR_BITS   = 184;
  localparam int unsigned POLY_COUNT = 24;
  localparam int unsigned POLY_TERMS = 9;

  localparam logic [3:0] LAST_MSG_CNT = 4'd8;
  localparam logic [4:0] LAST_PAR_IDX = 5'd22;

  // minimal polynomials, octal, x^0 in bit 0
  localparam logic [POLY_TERMS-1:0] MIN_POLY [POLY_COUNT] = '{
    9'o435, 9'o567, 9'o763, 9'o551, 9'o675, 9'o747, 9'o453, 9'o727,
    9'o023, 9'o545, 9'o613, 9'o543, 9'o433, 9'o477, 9'o615, 9'o455,
    9'o537, 9'o771, 9'o703, 9'o471, 9'o651, 9'o037, 9'o607, 9'o661
  };

  // Product of the minimal polynomials, x^184 dropped; bit k is coef of x^k.
  function automatic logic [PAR_BITS-1:0] gen_poly();
    logic [PAR_BITS:0] coef;
    logic [PAR_BITS:0] prod;
    coef = {{PAR_BITS{1'b0}}, 1'b1};
    for (int m = 0; m < POLY_COUNT; m++) begin
      prod = '0;
      for (int j = 0; j < POLY_TERMS; j++) begin
        if (MIN_POLY[m][j]) begin
          prod = prod ^ (coef << j);
        end
      end
      coef = prod;
    end
    return coef[PAR_BITS-1:0];
  endfunction

  localparam logic [PAR_BITS-1:0] GEN_POLY = gen_poly();

  // one message bit into the remainder
  function automatic logic [PAR_BITS-1:0] lfsr_bit(input logic [PAR_BITS-1:0] rem,
                                                   input logic din);
    logic fb;
    fb = din ^ rem[PAR_BITS-1];
    return {rem[PAR_BITS-2:0], 1'b0} ^ (fb ? GEN_POLY : '0);
  endfunction

  // LFSR -> drain: parity load request
  typedef struct packed {
    logic                load;
    logic [3:0]          msg_cnt;
    logic [PAR_BITS-1:0] parity;
  } bch255_lfsr_t;

  // drain -> LFSR: buffer status
  typedef struct packed {
    logic busy;
    logic done;
  } bch255_drn_t;

endpackage

// File: sv/bch255_if.sv
interface bch255_in_if import bch255_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

interface bch255_out_if import bch255_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] parity_byte;
  logic [4:0] byte_index;
  logic       last;

  modport source(output valid, output parity_byte, output byte_index, output last,
                 input ready);
  modport sink(input valid, input parity_byte, input byte_index, input last,
               output ready);
endinterface

// File: sv/bch255_lfsr.sv
module bch255_lfsr import bch255_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  bch255_in_if.sink     in_if,
  input  bch255_drn_t   drn,
  output bch255_lfsr_t  lfsr
);

  logic [PAR_BITS-1:0] rem_r, rem_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  logic [PAR_BITS-1:0] step [0:8];
  logic                acc;
  logic                ninth;

  // ninth word may only go when the parity buffer is free or freeing
  assign ninth       = (cnt_r == LAST_MSG_CNT);
  assign in_if.ready = !ninth || !drn.busy || drn.done;
  assign acc         = in_if.valid && in_if.ready;

  // eight bit steps, MSB first
  always_comb begin
    step[0] = rem_r;
    for (int b = 0; b < 8; b++) begin
      step[b+1] = lfsr_bit(step[b], in_if.data_byte[7-b]);
    end
  end

  always_comb begin
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    lfsr.load   = 1'b0;
    lfsr.parity = step[7];   // ninth word: bit 0 not part of the message
    lfsr.msg_cnt = cnt_r;
    if (acc) begin
      if (ninth) begin
        rem_nxt   = '0;
        cnt_nxt   = '0;
        lfsr.load = 1'b1;
      end else begin
        rem_nxt = step[8];
        cnt_nxt = cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      cnt_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: sv/bch255_drain.sv
module bch255_drain import bch255_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  bch255_lfsr_t  lfsr,
  bch255_out_if.source  out_if,
  output bch255_drn_t   drn
);

  logic [PAR_BITS-1:0] buf_r, buf_nxt;
  logic [4:0]          idx_r, idx_nxt;
  logic                busy_r, busy_nxt;
  logic                take;

  assign take     = busy_r && out_if.ready;
  assign drn.busy = busy_r;
  assign drn.done = take && (idx_r == LAST_PAR_IDX);

  assign out_if.valid       = busy_r;
  assign out_if.parity_byte = buf_r[PAR_BITS-1 -: 8];
  assign out_if.byte_index  = idx_r;
  assign out_if.last        = (idx_r == LAST_PAR_IDX);

  always_comb begin
    buf_nxt  = buf_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (lfsr.load) begin
      buf_nxt  = lfsr.parity;
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (take) begin
      buf_nxt  = {buf_r[PAR_BITS-9:0], 8'h00};
      idx_nxt  = idx_r + 5'd1;
      busy_nxt = !drn.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

// File: sv/bch_255_71_systematic_encoder_core.sv
// Systematic BCH(255,71) encoder. Feed the 71 message bits as nine words,
// MSB first; only the upper seven bits of the ninth word are used. Each word
// is folded into a 184-bit remainder register (eight bit steps of the
// generator division in parallel XOR logic), so message words go in at one
// per cycle, only the ninth waiting as told below. The ninth word copies the
// finished remainder into a parity buffer and clears the remainder; the
// buffer then sends 23 parity words, most significant first, with byte_index
// 0..22 and last on index 22. Message words of the next block are taken while
// parity drains; only its ninth word waits until the buffer has sent (or is
// sending) its last word. Parity words go out at one per cycle while the sink
// is ready; the first is presented in the cycle after the ninth word. No
// configuration; reset clears the remainder, count, busy flag and byte index.
module bch_255_71_systematic_encoder_core import bch255_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  bch255_in_if.sink     in_if,
  bch255_out_if.source  out_if
);

  bch255_lfsr_t lfsr;
  bch255_drn_t  drn;

  // remainder update, message word count
  bch255_lfsr u_lfsr (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .drn   (drn),
    .lfsr  (lfsr)
  );

  // parity buffer and output sequencing
  bch255_drain u_drain (
    .clk    (clk),
    .rst_n  (rst_n),
    .lfsr   (lfsr),
    .out_if (out_if),
    .drn    (drn)
  );

  // ---- assertions ----
`include "bch_255_71_systematic_encoder_core_assert.svh"

  // count never runs past the ninth word
  `BCH255_AST_NOW(a_cnt_range, 1'b1, lfsr.msg_cnt <= LAST_MSG_CNT, "message count out of range")
  // a block end never lands on a buffer still holding unsent parity
  `BCH255_AST_NOW(a_no_overwrite, lfsr.load, !drn.busy || drn.done, "parity buffer overwritten")
  // block end starts a fresh parity burst at index 0
  `BCH255_AST_NXT(a_burst_start, lfsr.load, out_if.valid && out_if.byte_index == 5'd0,
                  "parity burst did not start")
  // mid-burst words keep coming
  `BCH255_AST_NXT(a_burst_cont, out_if.valid && out_if.ready && !out_if.last, out_if.valid,
                  "parity burst broken")

endmodule
